// ===== src/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement core.
`timescale 1ns / 1ps

package lrupr_pkg;

  // Width of the active frame count register.
  localparam int CFG_W = 5;
  // Width of the reported frame index.
  localparam int OUT_FRAME_W = 4;
  // Width of the running fault total.
  localparam int COUNT_W = 32;

  // Update command broadcast from the controller to every frame cell.
  typedef struct packed {
    logic upd;      // apply the update this cycle
    logic clear;    // end of sequence: drop recency and residency
    logic age_all;  // a fill ages every resident frame
    logic fill;     // a new frame joins the resident set
    logic wr_page;  // the selected frame takes the request page
  } cell_ctl_t;

  // Lookup status reported by every frame cell.
  typedef struct packed {
    logic match;   // resident and holds the request page
    logic oldest;  // resident and least recently used
  } cell_stat_t;

endpackage

// ===== src/lrupr_cell.sv =====
// One page frame: resident page, recency rank and residency flag.
`timescale 1ns / 1ps

module lrupr_cell
  import lrupr_pkg::*;
#(
  parameter int PAGE_BITS = 20,
  parameter int RANK_W    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic                 sel,
  input  logic [RANK_W-1:0]    limit,
  input  logic [RANK_W-1:0]    oldest_rank,
  input  logic [PAGE_BITS-1:0] req_page,
  input  logic                 prev_valid,
  output logic                 valid_o,
  output logic [RANK_W-1:0]    rank_o,
  output cell_stat_t           stat
);

  logic                 valid_r, valid_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;

  assign valid_o     = valid_r;
  assign rank_o      = rank_r;
  assign stat.match  = valid_r && (page_r == req_page);
  assign stat.oldest = valid_r && (rank_r == oldest_rank);

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    page_nxt  = page_r;
    if (ctl.upd) begin
      if (sel && ctl.wr_page) begin
        page_nxt = req_page;
      end
      if (ctl.clear) begin
        valid_nxt = 1'b0;
        rank_nxt  = '0;
      end else begin
        // The residency flags form a thermometer; a fill shifts it by one.
        if (ctl.fill) begin
          valid_nxt = prev_valid;
        end
        if (sel) begin
          rank_nxt = '0;
        end else if (valid_r && (ctl.age_all || (rank_r < limit))) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule

// ===== src/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement core: controller and row of frame cells.
`timescale 1ns / 1ps

// LRU page replacement core. A page reference is taken when start is high and
// busy is low; each reference goes through accept, lookup and update, the
// lookup across the row of frame cells followed by the rank update in those
// cells. Busy stays high through lookup and update, so a new reference is
// taken only once the previous one is through. The result appears on the out_
// ports for exactly one cycle, marked by out_valid, in the update cycle; the
// receiver cannot stall it and must take it then. cfg_ready is always high;
// the active frame count should only be written while busy is low.
module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Reference request channel.
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] in_page_number,
  input  logic                 in_last_access,
  // Result channel.
  output logic                 out_valid,
  output logic                 out_fault,
  output logic [OUT_FRAME_W-1:0] out_frame_index,
  output logic [COUNT_W-1:0]   out_fault_count,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_active_frames
);

  // Ranks and frame indexes share one width; the fill count can also hold
  // the full frame count.
  localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Configuration and sequence state.
  logic [CFG_W-1:0]     active_r;
  logic [CNT_W-1:0]     filled_r;
  logic [COUNT_W-1:0]   total_r;

  // The latched request.
  logic [PAGE_BITS-1:0] req_page_r;
  logic                 req_last_r;

  // The action decided during lookup and applied in the update cycle.
  logic [RANK_W-1:0]    act_frame_r;
  logic [RANK_W-1:0]    act_limit_r;
  logic                 act_fill_r;
  logic                 act_wr_r;

  // Result registers.
  logic                 out_valid_r;
  logic                 out_fault_r;
  logic [OUT_FRAME_W-1:0] out_frame_r;
  logic [COUNT_W-1:0]   out_count_r;

  // Cell row signals.
  cell_ctl_t            ctl;
  cell_stat_t           stat   [MAX_FRAMES];
  logic [RANK_W-1:0]    rank   [MAX_FRAMES];
  logic [MAX_FRAMES:0]  chain_valid;

  // Lookup results.
  logic                 hit;
  logic [RANK_W-1:0]    hit_idx;
  logic [RANK_W-1:0]    hit_rank;
  logic [RANK_W-1:0]    vic_idx;
  logic [RANK_W-1:0]    oldest_rank;
  logic [CAP_W-1:0]     act_ext;
  logic [CAP_W-1:0]     cap;
  logic                 do_fill;
  logic [RANK_W-1:0]    frame_sel;

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_fault       = out_fault_r;
  assign out_frame_index = out_frame_r;
  assign out_fault_count = out_count_r;

  // The least recently used resident frame carries rank filled - 1.
  assign oldest_rank = RANK_W'(filled_r - 1'b1);

  // Out-of-range capacities are clamped: zero acts as one, anything above the
  // built frame count acts as the full count.
  assign act_ext = CAP_W'(active_r);
  always_comb begin
    if (act_ext == '0) begin
      cap = CAP_W'(1);
    end else if (act_ext > CAP_W'(MAX_FRAMES)) begin
      cap = CAP_W'(MAX_FRAMES);
    end else begin
      cap = act_ext;
    end
  end

  // Resident pages are unique and resident ranks form a permutation, so at
  // most one cell matches and exactly one resident cell is oldest; the
  // encoders can simply OR the selected indexes together.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    hit_rank = '0;
    vic_idx  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit      = hit | stat[i].match;
      hit_idx  = hit_idx  | (stat[i].match  ? RANK_W'(i) : '0);
      hit_rank = hit_rank | (stat[i].match  ? rank[i]    : '0);
      vic_idx  = vic_idx  | (stat[i].oldest ? RANK_W'(i) : '0);
    end
  end

  // A miss fills the next free frame while the resident set is below
  // capacity. When capacity has been lowered below the resident count, every
  // miss replaces the least recently used of all resident frames.
  assign do_fill = !hit && (CAP_W'(filled_r) < cap);

  always_comb begin
    priority if (hit) begin
      frame_sel = hit_idx;
    end else if (do_fill) begin
      frame_sel = RANK_W'(filled_r);
    end else begin
      frame_sel = vic_idx;
    end
  end

  // Broadcast update command; the selected frame is picked per cell.
  assign ctl.upd     = (state_r == ST_UPD);
  assign ctl.clear   = req_last_r;
  assign ctl.age_all = act_fill_r;
  assign ctl.fill    = act_fill_r;
  assign ctl.wr_page = act_wr_r;

  // Row of frame cells. Residency is handed from each cell to the next, so
  // on a fill the first free frame picks up its neighbor's flag.
  assign chain_valid[0] = 1'b1;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .RANK_W    (RANK_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .sel         (act_frame_r == RANK_W'(g)),
      .limit       (act_limit_r),
      .oldest_rank (oldest_rank),
      .req_page    (req_page_r),
      .prev_valid  (chain_valid[g]),
      .valid_o     (chain_valid[g+1]),
      .rank_o      (rank[g]),
      .stat        (stat[g])
    );
  end

  // Sequencer: accept, look up, then apply the update while the result is
  // presented.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= CFG_W'(16);
      filled_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      act_fill_r  <= 1'b0;
      act_wr_r    <= 1'b0;
      req_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_LOOK);
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_active_frames;
      end
      if (state_r == ST_IDLE && start) begin
        req_last_r <= in_last_access;
      end
      if (state_r == ST_LOOK) begin
        act_fill_r <= do_fill;
        act_wr_r   <= !hit;
        // The result carries the total before any end-of-sequence clear.
        if (req_last_r) begin
          filled_r <= '0;
          total_r  <= '0;
        end else begin
          if (do_fill) begin
            filled_r <= filled_r + 1'b1;
          end
          if (!hit && (total_r != '1)) begin
            total_r <= total_r + 1'b1;
          end
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_page_r <= in_page_number;
    end
    if (state_r == ST_LOOK) begin
      act_frame_r <= frame_sel;
      act_limit_r <= hit ? hit_rank : oldest_rank;
      out_fault_r <= !hit;
      out_frame_r <= OUT_FRAME_W'(frame_sel);
      out_count_r <= (!hit && (total_r != '1)) ? (total_r + 1'b1) : total_r;
    end
  end

endmodule

// ===== sim/tb_lru_page_replacement_core.sv =====
// Self-checking testbench for the LRU page replacement core with a built-in recency predictor.
`timescale 1ns / 1ps

module tb_lru_page_replacement_core
  import lrupr_pkg::*;
();

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_W = 20;
  // Cycles with no request, result or register write before the run is declared hung.
  // Sender gaps and request handling are far shorter, so this limit is ample.
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP = 100;

  // One page reference waiting to be driven. The drain flag makes the driver hold
  // this request back until every earlier result has come out.
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last;
    logic              drain;
  } page_ref_t;

  // What the core should report for one reference.
  typedef struct packed {
    logic                   fault;
    logic [OUT_FRAME_W-1:0] frame;
    logic [COUNT_W-1:0]     count;
  } lru_outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [PAGE_W-1:0] in_page_number = '0;
  logic in_last_access = 1'b0;
  logic out_valid;
  logic out_fault;
  logic [OUT_FRAME_W-1:0] out_frame_index;
  logic [COUNT_W-1:0] out_fault_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_active_frames = '0;

  always #5 clk = ~clk;

  lru_page_replacement_core #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .in_last_access   (in_last_access),
    .out_valid        (out_valid),
    .out_fault        (out_fault),
    .out_frame_index  (out_frame_index),
    .out_fault_count  (out_fault_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_frames(cfg_active_frames)
  );

  // Stimulus waiting for the driver, and results owed by the core in request order.
  page_ref_t    page_refs[$];
  lru_outcome_t owed_outcomes[$];

  // Predictor state: resident page per frame, recency rank per frame (0 is the most
  // recently used), number of filled frames, running fault total and the capacity register.
  logic [PAGE_W-1:0] frame_page[MAX_FRAMES];
  int unsigned       frame_rank[MAX_FRAMES];
  int unsigned       frames_used = 0;
  logic [COUNT_W-1:0] faults_so_far = '0;
  logic [CFG_W-1:0]  capacity_reg = 5'd16;

  // Bookkeeping shared between the driver, the monitor and the stimulus process.
  logic req_taken = 1'b0;
  int   idle_left = 0;
  bit   bursty = 1'b0;
  int   cfg_writes = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   refs_taken = 0;
  int   hits_seen = 0;
  int   faults_seen = 0;
  int   evictions = 0;
  int   seq_ends = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("MISMATCH @%0t: %s", $time, what);
    end
    mismatches++;
  endtask

  // Make frame keep the most recent one. Every other filled frame whose rank is below
  // the given bound moves one step toward least recently used.
  function automatic void age_frames(input int unsigned keep, input int unsigned below);
    for (int i = 0; i < frames_used; i++) begin
      if (i != keep && frame_rank[i] < below) begin
        frame_rank[i]++;
      end
    end
    frame_rank[keep] = 0;
  endfunction

  // Work out hit or fault, the frame used and the fault total for one reference, and
  // advance the predictor's table the same way the core should.
  function automatic lru_outcome_t predict_reference(input logic [PAGE_W-1:0] page,
                                                     input logic last);
    lru_outcome_t res;
    int unsigned cap;
    int unsigned victim;
    int unsigned oldest;
    bit found;
    cap = int'(capacity_reg);
    // A capacity of zero behaves as one frame; anything above the built size is clamped.
    if (cap == 0) cap = 1;
    if (cap > MAX_FRAMES) cap = MAX_FRAMES;
    found = 1'b0;
    victim = 0;
    for (int i = 0; i < frames_used; i++) begin
      if (!found && frame_page[i] == page) begin
        found = 1'b1;
        victim = i;
      end
    end
    if (found) begin
      age_frames(victim, frame_rank[victim]);
    end else begin
      if (faults_so_far != '1) faults_so_far++;
      if (frames_used < cap) begin
        // Free frame left: fill it, and every resident frame gets one step older.
        victim = frames_used;
        frame_page[victim] = page;
        age_frames(victim, MAX_FRAMES + 1);
        frames_used++;
        frame_rank[victim] = 0;
      end else begin
        // Table full, or capacity lowered below the filled count: the least recently
        // used of all filled frames is replaced.
        oldest = frames_used - 1;
        victim = 0;
        found = 1'b0;
        for (int i = 0; i < frames_used; i++) begin
          if (!found && frame_rank[i] == oldest) begin
            found = 1'b1;
            victim = i;
          end
        end
        frame_page[victim] = page;
        age_frames(victim, oldest);
        evictions++;
      end
      found = 1'b0;
    end
    res.fault = !found;
    res.frame = victim[OUT_FRAME_W-1:0];
    res.count = faults_so_far;
    if (last) begin
      // End of sequence: recency and count restart, page contents stay behind.
      for (int i = 0; i < MAX_FRAMES; i++) frame_rank[i] = 0;
      frames_used = 0;
      faults_so_far = '0;
      seq_ends++;
    end
    return res;
  endfunction

  // Random gap after a request: mostly none, some short, a few long. In bursty phases
  // the sender never idles, so requests are offered back to back.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (bursty || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // Driver: changes the request inputs at the falling edge. A request stays on the
  // ports until the monitor has seen it accepted; then either a gap follows or the
  // next request from the queue goes out in the same step.
  always @(negedge clk) begin
    page_ref_t nxt;
    if (rst_n) begin
      if (start && !req_taken) begin
        // Still waiting for the core to take the current request.
      end else if (idle_left > 0) begin
        start <= 1'b0;
        idle_left = idle_left - 1;
      end else if (page_refs.size() > 0 &&
                   !(page_refs[0].drain && owed_outcomes.size() > 0)) begin
        nxt = page_refs.pop_front();
        start <= 1'b1;
        in_page_number <= nxt.page;
        in_last_access <= nxt.last;
        idle_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: samples everything at the rising edge. Results are checked before a new
  // request is predicted, since a request taken at this edge cannot have its result yet.
  always @(posedge clk) begin
    lru_outcome_t want;
    bit progress;
    if (rst_n) begin
      progress = 1'b0;
      if (cfg_valid && cfg_ready) begin
        capacity_reg = cfg_active_frames;
        cfg_writes++;
        progress = 1'b1;
      end
      if (out_valid) begin
        progress = 1'b1;
        if (owed_outcomes.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = owed_outcomes.pop_front();
          if (out_fault !== want.fault)
            report_mismatch($sformatf("fault %b, expected %b", out_fault, want.fault));
          if (out_frame_index !== want.frame)
            report_mismatch($sformatf("frame_index %0d, expected %0d",
                                      out_frame_index, want.frame));
          if (out_fault_count !== want.count)
            report_mismatch($sformatf("fault_count %0d, expected %0d",
                                      out_fault_count, want.count));
          if (want.fault) faults_seen++;
          else hits_seen++;
        end
      end
      if (start && !busy) begin
        owed_outcomes.push_back(predict_reference(in_page_number, in_last_access));
        refs_taken++;
        progress = 1'b1;
      end
      req_taken <= start && !busy;
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request, result or register write for %0d cycles",
                 QUIET_LIMIT);
        $display("tb_lru_page_replacement_core: errors");
        $finish;
      end
    end
  end

  task automatic add_ref(input logic [PAGE_W-1:0] page, input logic last,
                         input logic drain);
    page_ref_t r;
    r.page = page;
    r.last = last;
    r.drain = drain;
    page_refs.push_back(r);
  endtask

  // Wait until every queued request has been taken and every result has come out,
  // then let the core finish its update before a register write.
  task automatic wait_idle();
    do @(negedge clk);
    while (page_refs.size() > 0 || start || owed_outcomes.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  // Write the active frame count; called at a falling edge while the core is idle.
  task automatic write_capacity(input logic [CFG_W-1:0] value);
    int seen;
    seen = cfg_writes;
    cfg_active_frames <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  // A random sequence of references drawn mostly from a small window of pages, so that
  // hits, fills and replacements all happen. Some pages are fully random noise, an
  // occasional stray end marker cuts a sequence short, and a few requests wait for
  // the result queue to drain first. A sequence may also be left open so that the
  // next capacity write lands in the middle of it.
  task automatic add_sequence();
    int len;
    int pool;
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;
    bit close_it;
    len = $urandom_range(1, 40);
    pool = $urandom_range(1, 24);
    base = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 64));
    close_it = ($urandom_range(0, 3) != 0);
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
      else page = PAGE_W'(base + $urandom_range(0, pool - 1));
      add_ref(page, (j == len - 1 && close_it) || $urandom_range(0, 59) == 0,
              $urandom_range(0, 49) == 0);
    end
  endtask

  initial begin
    int queued;
    logic [CFG_W-1:0] cap_plan[7];
    cap_plan = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd0, 5'd17, 5'd3};

    // Synchronous reset, released at a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset capacity of 16, the lowest and highest page numbers, hits on
    // both, and a fresh start after an end-of-sequence marker.
    add_ref('0, 1'b0, 1'b0);
    add_ref('1, 1'b0, 1'b0);
    add_ref('0, 1'b0, 1'b0);
    add_ref('1, 1'b1, 1'b0);
    add_ref('0, 1'b0, 1'b0);
    add_ref('1, 1'b1, 1'b0);
    wait_idle();

    // Directed: fill eight frames, then drop the capacity to zero (which behaves as
    // one) in the middle of the sequence. The old frames must still hit, and a miss
    // must replace the least recently used of all eight.
    write_capacity(5'd8);
    for (int i = 0; i < 8; i++) add_ref(PAGE_W'(20'h00100 + i), 1'b0, 1'b0);
    wait_idle();
    write_capacity(5'd0);
    add_ref(20'h00103, 1'b0, 1'b0);
    add_ref(20'h00200, 1'b0, 1'b0);
    add_ref(20'h00201, 1'b0, 1'b0);
    add_ref(20'h00103, 1'b1, 1'b0);

    // Random rounds, each under its own capacity: first the extremes and out-of-range
    // values, then random ones. Every third round the sender never idles.
    for (int round = 0; round < 12; round++) begin
      wait_idle();
      write_capacity(round < 7 ? cap_plan[round] : CFG_W'($urandom_range(0, 31)));
      bursty = (round % 3 == 1);
      queued = page_refs.size();
      while (page_refs.size() - queued < 125) add_sequence();
    end

    wait_idle();
    $display("Covered %0d references: %0d hits, %0d faults, %0d replacements, %0d ends.",
             refs_taken, hits_seen, faults_seen, evictions, seq_ends);
    $display("Capacity register written %0d times, including 0, 1, 16, 17 and 31.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("tb_lru_page_replacement_core: clean");
    end else begin
      $display("tb_lru_page_replacement_core: errors");
    end
    $finish;
  end

endmodule

// ===== lru_page_replacement_core.f =====
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lru_page_replacement_core.sv
sim/tb_lru_page_replacement_core.sv
